@@ hw/rtl/bpf_pkg.sv @@
// shared types and constants for the branch power flow pipeline
package bpf_pkg;

	// one operating point of the branch
	typedef struct packed {
		logic [15:0] volt_from;
		logic [15:0] volt_to;
		logic [15:0] angle_from;
		logic [15:0] angle_to;
	} point_t;

	// branch flows for one operating point, Q12.20
	typedef struct packed {
		logic signed [31:0] p_from_to;
		logic signed [31:0] p_to_from;
		logic signed [31:0] q_from_to;
		logic signed [31:0] q_to_from;
		logic signed [31:0] active_loss;
	} flow_t;

	// register map, word index
	typedef enum logic [1:0] {
		REG_G   = 2'd0,
		REG_B   = 2'd1,
		REG_BSH = 2'd2
	} reg_idx_t;

	// cordic datapath
	localparam int CORDIC_W  = 32;
	localparam int ATAN_DEPTH = 24;
	// 1/K in Q2.30, start value of x
	localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 32'sd652032874;

	// arctangent of 2^-i in units of 2^-32 turn
	localparam logic signed [CORDIC_W-1:0] ATAN_TURN [ATAN_DEPTH] = '{
		32'sd536870912, 32'sd316933405, 32'sd167458907, 32'sd85004756,
		32'sd42667331,  32'sd21354465,  32'sd10680862,  32'sd5337595,
		32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
		32'sd166886,    32'sd83443,     32'sd41721,     32'sd20860,
		32'sd10430,     32'sd5215,      32'sd2607,      32'sd1303,
		32'sd651,       32'sd325,       32'sd162,       32'sd81
	};

	// side data carried along the cordic: reflect flag and both voltages
	localparam int SIDE_W = 33;

endpackage

@@ hw/rtl/bpf_cordic.sv @@
// rotation-mode cordic pipeline, one micro-rotation per register stage
module bpf_cordic
	import bpf_pkg::*;
#(
	parameter int STAGES = 16
) (
	input  logic                       clk,
	input  logic [STAGES-1:0]          ld,
	input  logic signed [CORDIC_W-1:0] z_in,
	input  logic [SIDE_W-1:0]          side_in,
	output logic signed [CORDIC_W-1:0] cos_raw,
	output logic signed [CORDIC_W-1:0] sin_raw,
	output logic [SIDE_W-1:0]          side_out
);

	logic signed [CORDIC_W-1:0] x_s [STAGES];
	logic signed [CORDIC_W-1:0] y_s [STAGES];
	logic signed [CORDIC_W-1:0] z_s [STAGES];
	logic [SIDE_W-1:0]          side_s [STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic signed [CORDIC_W-1:0] xp;
		logic signed [CORDIC_W-1:0] yp;
		logic signed [CORDIC_W-1:0] zp;
		logic signed [CORDIC_W-1:0] xsh;
		logic signed [CORDIC_W-1:0] ysh;
		logic [SIDE_W-1:0]          sp;

		// first stage starts from the gain-compensated unit vector
		if (k == 0) begin : g_first
			assign xp = GAIN_Q30;
			assign yp = '0;
			assign zp = z_in;
			assign sp = side_in;
		end else begin : g_next
			assign xp = x_s[k-1];
			assign yp = y_s[k-1];
			assign zp = z_s[k-1];
			assign sp = side_s[k-1];
		end

		assign xsh = xp >>> k;
		assign ysh = yp >>> k;

		// rotate toward zero residual angle
		always_ff @(posedge clk) begin
			if (ld[k]) begin
				if (!zp[CORDIC_W-1]) begin
					x_s[k] <= xp - ysh;
					y_s[k] <= yp + xsh;
					z_s[k] <= zp - ATAN_TURN[k];
				end else begin
					x_s[k] <= xp + ysh;
					y_s[k] <= yp - xsh;
					z_s[k] <= zp + ATAN_TURN[k];
				end
				side_s[k] <= sp;
			end
		end
	end

	assign cos_raw  = x_s[STAGES-1];
	assign sin_raw  = y_s[STAGES-1];
	assign side_out = side_s[STAGES-1];

endmodule

@@ hw/rtl/branch_power_flow_top.sv @@
// top level of the branch power flow pipeline with its register port
//
// AC power flow on one branch (pi model). A request on the point channel
// carries both bus voltages (Q2.14) and phase angles (1/65536 turn); one
// request on the flow channel returns P and Q in both directions and the
// active loss, Q12.20, each saturated to 32 bits.
// Branch g, b and bsh (Q8.16) sit in APB registers at 0x0, 0x4 and 0x8; the
// user must write them only while the pipeline is empty, which the block
// itself does not enforce. The pipeline has one input stage, one cordic
// micro-rotation per stage, then round, product, sum, product and output
// stages. A new point enters every cycle unless point_stall is high; the
// cordic length and the two multiplier rows set latency, not throughput.
// Every stage has its own valid bit and loads when it is empty or the next
// stage loads, so a stall on the flow channel is absorbed by bubbles
// first and reaches point_stall only when all stages are full.
// Reset clears the valid bits and the three branch registers to zero.
module branch_power_flow_top
	import bpf_pkg::*;
#(
	parameter int CORDIC_STAGES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// point channel
	input  logic        point_valid,
	output logic        point_stall,
	input  point_t      point,
	// flow channel
	output logic        flow_valid,
	input  logic        flow_stall,
	output flow_t       flow,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int ST_S2  = CORDIC_STAGES + 1;
	localparam int ST_S3  = CORDIC_STAGES + 2;
	localparam int ST_S4  = CORDIC_STAGES + 3;
	localparam int ST_S5  = CORDIC_STAGES + 4;
	localparam int ST_OUT = CORDIC_STAGES + 5;
	localparam int NST    = CORDIC_STAGES + 6;

	// saturating round of a Q.44 sum to Q12.20
	function automatic logic signed [31:0] sat_q20(input logic signed [65:0] v);
		logic signed [65:0] t;
		logic signed [41:0] r;
		t = v + 66'sd8388608;
		r = t[65:24];
		if (r > 42'sd2147483647)
			return 32'sh7fffffff;
		else if (r < -42'sd2147483648)
			return 32'sh80000000;
		else
			return r[31:0];
	endfunction

	// branch registers
	logic signed [23:0] g_q;
	logic signed [23:0] b_q;
	logic signed [23:0] bsh_q;
	logic signed [24:0] bt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_q   <= '0;
			b_q   <= '0;
			bsh_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_G:   g_q   <= pwdata[23:0];
				REG_B:   b_q   <= pwdata[23:0];
				REG_BSH: bsh_q <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	// register read back, sign extended
	always_comb begin
		case (paddr[3:2])
			REG_G:   prdata = {{8{g_q[23]}}, g_q};
			REG_B:   prdata = {{8{b_q[23]}}, b_q};
			REG_BSH: prdata = {{8{bsh_q[23]}}, bsh_q};
			default: prdata = '0;
		endcase
	end

	assign pready = 1'b1;
	assign bt     = {b_q[23], b_q} + {bsh_q[23], bsh_q};

	// per-stage valid bits and load enables
	logic [NST-1:0] stage_vld_q;
	logic [NST:0]   ready;

	assign ready[NST] = !flow_stall;
	for (genvar k = 0; k < NST; k++) begin : g_ready
		assign ready[k] = !stage_vld_q[k] || ready[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (ready[0])
				stage_vld_q[0] <= point_valid;
			for (int k = 1; k < NST; k++) begin
				if (ready[k])
					stage_vld_q[k] <= stage_vld_q[k-1];
			end
		end
	end

	assign point_stall = !ready[0];
	assign flow_valid  = stage_vld_q[ST_OUT];

	// s1: angle difference, fold into the right half plane
	logic [15:0]               diff;
	logic signed [16:0]        dsx;
	logic signed [16:0]        dfold;
	logic                      flip;
	logic signed [CORDIC_W-1:0] z_s1;
	logic                      flip_s1;
	logic [15:0]               vk_s1;
	logic [15:0]               vm_s1;

	always_comb begin
		diff  = point.angle_from - point.angle_to;
		dsx   = {diff[15], diff};
		flip  = 1'b0;
		dfold = dsx;
		if (dsx > 17'sd16384) begin
			dfold = dsx - 17'sd32768;
			flip  = 1'b1;
		end else if (dsx < -17'sd16384) begin
			dfold = dsx + 17'sd32768;
			flip  = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready[0]) begin
			z_s1    <= {dfold[15:0], 16'b0};
			flip_s1 <= flip;
			vk_s1   <= point.volt_from;
			vm_s1   <= point.volt_to;
		end
	end

	// cordic stages
	logic signed [CORDIC_W-1:0] cos_raw;
	logic signed [CORDIC_W-1:0] sin_raw;
	logic [SIDE_W-1:0]          side_out;

	bpf_cordic #(
		.STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk      (clk),
		.ld       (ready[CORDIC_STAGES:1]),
		.z_in     (z_s1),
		.side_in  ({flip_s1, vk_s1, vm_s1}),
		.cos_raw  (cos_raw),
		.sin_raw  (sin_raw),
		.side_out (side_out)
	);

	// s2: round cosine and sine to Q2.20, undo the fold, voltage products
	logic signed [32:0] cos_rnd;
	logic signed [32:0] sin_rnd;
	logic signed [23:0] cos_ext;
	logic signed [23:0] sin_ext;
	logic signed [23:0] cos_s2;
	logic signed [23:0] sin_s2;
	logic [31:0]        vkk_s2;
	logic [31:0]        vmm_s2;
	logic [31:0]        vkm_s2;

	assign cos_rnd = 33'(cos_raw) + 33'sd512;
	assign sin_rnd = 33'(sin_raw) + 33'sd512;
	assign cos_ext = {cos_rnd[32], cos_rnd[32:10]};
	assign sin_ext = {sin_rnd[32], sin_rnd[32:10]};

	always_ff @(posedge clk) begin
		if (ready[ST_S2]) begin
			cos_s2 <= side_out[32] ? -cos_ext : cos_ext;
			sin_s2 <= side_out[32] ? -sin_ext : sin_ext;
			vkk_s2 <= side_out[31:16] * side_out[31:16];
			vmm_s2 <= side_out[15:0] * side_out[15:0];
			vkm_s2 <= side_out[31:16] * side_out[15:0];
		end
	end

	// s3: first multiplier row
	logic signed [47:0] gc_s3;
	logic signed [47:0] bs_s3;
	logic signed [47:0] bc_s3;
	logic signed [47:0] gs_s3;
	logic signed [56:0] kc_s3;
	logic signed [56:0] gvkk_s3;
	logic signed [56:0] gvmm_s3;
	logic signed [57:0] btvkk_s3;
	logic signed [57:0] btvmm_s3;
	logic [31:0]        vkk_s3;
	logic [31:0]        vmm_s3;
	logic [31:0]        vkm_s3;

	always_ff @(posedge clk) begin
		if (ready[ST_S3]) begin
			gc_s3    <= g_q * cos_s2;
			bs_s3    <= b_q * sin_s2;
			bc_s3    <= b_q * cos_s2;
			gs_s3    <= g_q * sin_s2;
			kc_s3    <= $signed({1'b0, vkm_s2}) * cos_s2;
			gvkk_s3  <= g_q * $signed({1'b0, vkk_s2});
			gvmm_s3  <= g_q * $signed({1'b0, vmm_s2});
			btvkk_s3 <= bt * $signed({1'b0, vkk_s2});
			btvmm_s3 <= bt * $signed({1'b0, vmm_s2});
			vkk_s3   <= vkk_s2;
			vmm_s3   <= vmm_s2;
			vkm_s3   <= vkm_s2;
		end
	end

	// s4: admittance mixes rounded to Q.16, loss bracket rounded to Q.28
	logic signed [49:0] gcpbs_sum;
	logic signed [49:0] gcmbs_sum;
	logic signed [49:0] bcmgs_sum;
	logic signed [49:0] bcpgs_sum;
	logic signed [59:0] br_sum;
	logic signed [29:0] gcpbs_s4;
	logic signed [29:0] gcmbs_s4;
	logic signed [29:0] bcmgs_s4;
	logic signed [29:0] bcpgs_s4;
	logic signed [39:0] br_s4;
	logic signed [56:0] gvkk_s4;
	logic signed [56:0] gvmm_s4;
	logic signed [57:0] btvkk_s4;
	logic signed [57:0] btvmm_s4;
	logic [31:0]        vkm_s4;

	assign gcpbs_sum = 50'(gc_s3) + 50'(bs_s3) + 50'sd524288;
	assign gcmbs_sum = 50'(gc_s3) - 50'(bs_s3) + 50'sd524288;
	assign bcmgs_sum = 50'(bc_s3) - 50'(gs_s3) + 50'sd524288;
	assign bcpgs_sum = 50'(bc_s3) + 50'(gs_s3) + 50'sd524288;
	assign br_sum    = $signed({8'b0, vkk_s3, 20'b0}) + $signed({8'b0, vmm_s3, 20'b0})
		- (60'(kc_s3) <<< 1) + 60'sd524288;

	always_ff @(posedge clk) begin
		if (ready[ST_S4]) begin
			gcpbs_s4 <= gcpbs_sum[49:20];
			gcmbs_s4 <= gcmbs_sum[49:20];
			bcmgs_s4 <= bcmgs_sum[49:20];
			bcpgs_s4 <= bcpgs_sum[49:20];
			br_s4    <= br_sum[59:20];
			gvkk_s4  <= gvkk_s3;
			gvmm_s4  <= gvmm_s3;
			btvkk_s4 <= btvkk_s3;
			btvmm_s4 <= btvmm_s3;
			vkm_s4   <= vkm_s3;
		end
	end

	// s5: second multiplier row
	logic signed [62:0] m0_s5;
	logic signed [62:0] m1_s5;
	logic signed [62:0] m2_s5;
	logic signed [62:0] m3_s5;
	logic signed [63:0] loss_s5;
	logic signed [56:0] gvkk_s5;
	logic signed [56:0] gvmm_s5;
	logic signed [57:0] btvkk_s5;
	logic signed [57:0] btvmm_s5;

	always_ff @(posedge clk) begin
		if (ready[ST_S5]) begin
			m0_s5    <= $signed({1'b0, vkm_s4}) * gcpbs_s4;
			m1_s5    <= $signed({1'b0, vkm_s4}) * gcmbs_s4;
			m2_s5    <= $signed({1'b0, vkm_s4}) * bcmgs_s4;
			m3_s5    <= $signed({1'b0, vkm_s4}) * bcpgs_s4;
			loss_s5  <= g_q * br_s4;
			gvkk_s5  <= gvkk_s4;
			gvmm_s5  <= gvmm_s4;
			btvkk_s5 <= btvkk_s4;
			btvmm_s5 <= btvmm_s4;
		end
	end

	// s6: final sums, round and saturate into the output register
	flow_t flow_s6;

	always_ff @(posedge clk) begin
		if (ready[ST_OUT]) begin
			flow_s6.p_from_to   <= sat_q20(66'(gvkk_s5) - 66'(m0_s5));
			flow_s6.p_to_from   <= sat_q20(66'(gvmm_s5) - 66'(m1_s5));
			flow_s6.q_from_to   <= sat_q20(66'(m2_s5) - 66'(btvkk_s5));
			flow_s6.q_to_from   <= sat_q20(66'(m3_s5) - 66'(btvmm_s5));
			flow_s6.active_loss <= sat_q20(66'(loss_s5));
		end
	end

	assign flow = flow_s6;

	// a stall reaches the point channel only when every stage holds a request
	assert property (@(posedge clk) disable iff (!arst_n)
		(point_stall |-> (&stage_vld_q && flow_stall)))
		else $error("point channel stalled with room in the pipeline");

	// an accepted request always lands in the first stage
	assert property (@(posedge clk) disable iff (!arst_n)
		((point_valid && !point_stall) |=> stage_vld_q[0]))
		else $error("accepted request lost at the first stage");

	// rounded cosine and sine stay within the unit circle plus cordic error
	assert property (@(posedge clk) disable iff (!arst_n)
		(stage_vld_q[ST_S2] |-> (cos_s2 <= 24'sd1049600 && cos_s2 >= -24'sd1049600
			&& sin_s2 <= 24'sd1049600 && sin_s2 >= -24'sd1049600)))
		else $error("cordic output out of range");

endmodule

@@ sim/testbench.sv @@
// self-checking testbench for the branch power flow pipeline, directed and random points
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import bpf_pkg::*;

	localparam int STAGES = 16;
	localparam int LATENCY = STAGES + 6;
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASE_POINTS = 300;
	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam flow_t NO_FLOW = '0;

	// cordic constants: start gain in Q2.30, arctangents in 2^-32 turn
	localparam longint CORDIC_GAIN = 652032874;
	localparam longint ATAN_Q32 [24] = '{
		536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
		10680862, 5337595, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41721, 20860, 10430, 5215,
		2607, 1303, 651, 325, 162, 81
	};
	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;

	// angle differences around the reflection and wrap points
	localparam logic [15:0] TURN_EDGES [12] = '{
		16'h0000, 16'h0001, 16'hFFFF, 16'h3FFF, 16'h4000, 16'h4001,
		16'h7FFF, 16'h8000, 16'h8001, 16'hBFFF, 16'hC000, 16'hC001
	};

	// directed points; typed rows carry a zero voltage on both buses
	typedef struct packed {
		point_t pt;
		logic   typed;
		flow_t  want;
	} dir_row_t;

	localparam dir_row_t DIR_ROWS [8] = '{
		'{'{16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, NO_FLOW},
		'{'{16'h0000, 16'h0000, 16'hFFFF, 16'h0000}, 1'b1, NO_FLOW},
		'{'{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000}, 1'b0, NO_FLOW},
		'{'{16'hFFFF, 16'hFFFF, 16'h8000, 16'h0000}, 1'b0, NO_FLOW},
		'{'{16'hFFFF, 16'h0000, 16'h4000, 16'h0000}, 1'b0, NO_FLOW},
		'{'{16'h4000, 16'h4000, 16'h0000, 16'h4000}, 1'b0, NO_FLOW},
		'{'{16'h4000, 16'hFFFF, 16'h4001, 16'h0000}, 1'b0, NO_FLOW},
		'{'{16'h7FFF, 16'h8000, 16'h0000, 16'h4001}, 1'b0, NO_FLOW}
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        point_valid = 1'b0;
	logic        point_stall;
	point_t      point = '0;
	logic        flow_valid;
	logic        flow_stall = 1'b0;
	flow_t       flow;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// branch registers as the predictor sees them
	longint branch_g = 0;
	longint branch_b = 0;
	longint branch_bsh = 0;

	flow_t pending_flows [$];
	int    mismatches = 0;
	int    points_sent = 0;
	int    flows_checked = 0;
	int    settings_used = 1;
	int    held_cycles = 0;
	int    hold_request = 0;
	int    cycles = 0;
	bit    calm = 1'b0;

	branch_power_flow_top #(
		.CORDIC_STAGES(STAGES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.point(point),
		.flow_valid(flow_valid),
		.flow_stall(flow_stall),
		.flow(flow),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// round half up: add half, floor shift
	function automatic longint round_q(input longint v, input int sh);
		return (v + (longint'(1) << (sh - 1))) >>> sh;
	endfunction

	// Q.44 down to Q12.20 with saturation
	function automatic logic [31:0] to_q20(input longint q44);
		longint v;
		v = round_q(q44, 24);
		if (v > SAT_HI)
			v = SAT_HI;
		if (v < SAT_LO)
			v = SAT_LO;
		return v[31:0];
	endfunction

	// cosine and sine of a turn fraction, Q2.20
	function automatic void cordic_sincos(input logic [15:0] ang, output longint c,
		output longint s);
		longint d, x, y, z, xs, ys;
		bit flip;
		int i;
		d = longint'(ang);
		if (d >= 32768)
			d -= 65536;
		flip = 1'b0;
		// beyond a quarter turn: rotate by half a turn and negate
		if (d > 16384) begin
			d -= 32768;
			flip = 1'b1;
		end else if (d < -16384) begin
			d += 32768;
			flip = 1'b1;
		end
		z = d * 65536;
		x = CORDIC_GAIN;
		y = 0;
		for (i = 0; i < STAGES && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys;
				y += xs;
				z -= ATAN_Q32[i];
			end else begin
				x += ys;
				y -= xs;
				z += ATAN_Q32[i];
			end
		end
		x = round_q(x, 10);
		y = round_q(y, 10);
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	// branch flows for one operating point under the current registers
	function automatic flow_t predict_flow(input point_t p);
		longint vk, vm, c, s, vkk, vmm, vkm, bt, gc_p, gc_m, bc_m, bc_p, brk;
		logic [15:0] diff;
		flow_t f;
		vk = longint'(p.volt_from);
		vm = longint'(p.volt_to);
		diff = p.angle_from - p.angle_to;
		cordic_sincos(diff, c, s);
		vkk = vk * vk;
		vmm = vm * vm;
		vkm = vk * vm;
		bt = branch_b + branch_bsh;
		gc_p = round_q(branch_g * c + branch_b * s, 20);
		gc_m = round_q(branch_g * c - branch_b * s, 20);
		bc_m = round_q(branch_b * c - branch_g * s, 20);
		bc_p = round_q(branch_b * c + branch_g * s, 20);
		f.p_from_to = to_q20(branch_g * vkk - vkm * gc_p);
		f.p_to_from = to_q20(branch_g * vmm - vkm * gc_m);
		f.q_from_to = to_q20(-bt * vkk + vkm * bc_m);
		f.q_to_from = to_q20(-bt * vmm + vkm * bc_p);
		// loss bracket in Q.48, down to Q.28 before the conductance
		brk = round_q(vkk * 1048576 + vmm * 1048576 - 2 * vkm * c, 20);
		f.active_loss = to_q20(branch_g * brk);
		return f;
	endfunction

	function automatic logic [15:0] corner_volt();
		case ($urandom_range(0, 3))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h4000;
			default: return 16'($urandom);
		endcase
	endfunction

	// mostly near-nominal operating points, some wide and corner ones
	function automatic point_t random_point();
		point_t p;
		logic [15:0] diff;
		int kind;
		kind = $urandom_range(0, 9);
		p = {$urandom, $urandom};
		if (kind <= 5) begin
			p.volt_from = 16'd14745 + 16'($urandom_range(0, 3277));
			p.volt_to = 16'd14745 + 16'($urandom_range(0, 3277));
			diff = 16'($urandom_range(0, 4000)) - 16'd2000;
			p.angle_from = p.angle_to + diff;
		end else if (kind == 8) begin
			diff = TURN_EDGES[$urandom_range(0, 11)];
			p.angle_from = p.angle_to + diff;
		end else if (kind == 9) begin
			p.volt_from = corner_volt();
			p.volt_to = corner_volt();
		end
		return p;
	endfunction

	// one register access, setup then access phase
	task automatic apb_access(input bit wr, input logic [3:0] addr, input logic [31:0] wdata,
		output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// write one register and, unless it is the spare, read it back
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		logic [31:0] rd;
		apb_access(1'b1, {idx, 2'b00}, val, rd);
		case (idx)
			REG_G: branch_g = longint'($signed(val[23:0]));
			REG_B: branch_b = longint'($signed(val[23:0]));
			REG_BSH: branch_bsh = longint'($signed(val[23:0]));
			default: ;
		endcase
		if (idx != REG_SPARE) begin
			apb_access(1'b0, {idx, 2'b00}, '0, rd);
			if (rd[23:0] !== val[23:0]) begin
				$display("%0t register %0d readback: expected %h, got %h",
					$time, idx, val[23:0], rd[23:0]);
				mismatches++;
			end
		end
	endtask

	// hold new requests until every flow is back and the pipeline is empty
	task automatic drain_flows();
		point_valid <= 1'b0;
		while (pending_flows.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 2) @(negedge clk);
	endtask

	task automatic program_branch(input logic [23:0] g, input logic [23:0] b,
		input logic [23:0] bsh);
		drain_flows();
		write_reg(REG_G, {8'($urandom), g});
		write_reg(REG_B, {8'($urandom), b});
		write_reg(REG_BSH, {8'($urandom), bsh});
		write_reg(REG_SPARE, $urandom);
		settings_used++;
	endtask

	// offer one point, maybe after an idle burst, and log its flow
	task automatic offer_point(input point_t p, input logic typed, input flow_t want);
		if (!calm && $urandom_range(0, 5) == 0) begin
			point_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		point <= p;
		point_valid <= 1'b1;
		do @(posedge clk); while (point_stall);
		pending_flows.push_back(typed ? want : predict_flow(p));
		points_sent++;
		@(negedge clk);
	endtask

	// flow side stall: random bursts, or one long hold when asked
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end
			if (stall_left > 0) begin
				flow_stall <= 1'b1;
				stall_left--;
			end else begin
				flow_stall <= 1'b0;
				if (!calm && $urandom_range(0, 6) == 0)
					stall_left = $urandom_range(1, 8);
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t flow %0d %s: expected %0d, got %0d",
				$time, flows_checked, name, $signed(want), $signed(got));
			mismatches++;
		end
	endtask

	// compare each accepted flow with the oldest expectation
	always @(posedge clk) begin : check_flows
		flow_t want;
		if (arst_n && point_valid && point_stall)
			held_cycles++;
		if (arst_n && flow_valid && !flow_stall) begin
			if (pending_flows.size() == 0) begin
				$display("%0t flow with no request outstanding: %h", $time, flow);
				mismatches++;
			end else begin
				want = pending_flows.pop_front();
				check_field("p_from_to", want.p_from_to, flow.p_from_to);
				check_field("p_to_from", want.p_to_from, flow.p_to_from);
				check_field("q_from_to", want.q_from_to, flow.q_from_to);
				check_field("q_to_from", want.q_to_from, flow.q_to_from);
				check_field("active_loss", want.active_loss, flow.active_loss);
			end
			flows_checked++;
		end
	end

	// watchdog
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t timeout with %0d flows outstanding", $time, pending_flows.size());
		$display("tb: failure");
		$finish;
	end

	initial begin
		int w, ph, k;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed points under reset values, then both register extremes
		for (w = 0; w < 3; w++) begin
			if (w == 1)
				program_branch(24'h7FFFFF, 24'h800000, 24'h7FFFFF);
			if (w == 2)
				program_branch(24'h800000, 24'h7FFFFF, 24'h800000);
			foreach (DIR_ROWS[r])
				offer_point(DIR_ROWS[r].pt, DIR_ROWS[r].typed, DIR_ROWS[r].want);
		end

		// random points under several branch settings
		for (ph = 0; ph < 6; ph++) begin
			case (ph)
				0, 4: program_branch(24'($urandom_range(0, 1310720)),
					24'(0 - $urandom_range(0, 3932160)), 24'($urandom_range(0, 131072)));
				2: program_branch(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
				3: program_branch(24'h800000, 24'h800000, 24'h800000);
				default: program_branch(24'($urandom), 24'($urandom), 24'($urandom));
			endcase
			// last stretch runs with no idling on either side
			if (ph == 5)
				calm = 1'b1;
			for (k = 0; k < PHASE_POINTS; k++) begin
				if (ph == 4 && k == 100)
					hold_request = 90;
				if (ph == 1 && k == 150)
					drain_flows();
				offer_point(random_point(), 1'b0, NO_FLOW);
			end
		end

		point_valid <= 1'b0;
		while (pending_flows.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		$display("tb: %0d operating points over %0d branch settings, %0d flows compared",
			points_sent, settings_used, flows_checked);
		$display("tb: point channel held off %0d cycles, %0d mismatches",
			held_cycles, mismatches);
		if (mismatches == 0 && pending_flows.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/bpf_pkg.sv
hw/rtl/bpf_cordic.sv
hw/rtl/branch_power_flow_top.sv
sim/testbench.sv
